FILE: hdl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// shared widths, constants and arctangent table for the point transform
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int ANGLE_W = 32;   // binary angle, full turn is 2^32
    localparam int Z_W     = 34;   // residual angle inside the cordic
    localparam int TRIG_W  = 33;   // cordic x/y, q1.30 with headroom
    localparam int FRAC_W  = 30;   // fraction bits of the trig values
    localparam int MAX_STAGES = 32;

    // 1/K in q1.30, preloaded so the cordic result needs no gain fix-up
    localparam logic signed [TRIG_W-1:0] GAIN_INV   = 33'sd652032874;
    // eighth of a turn, beyond it the angle is folded by half a turn
    localparam logic signed [Z_W-1:0]    FOLD_LIMIT = 34'sd536870912;
    localparam logic signed [Z_W-1:0]    HALF_TURN  = 34'sd2147483648;

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [29:0] ATAN_TAB [MAX_STAGES] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        atan_entry = $signed({{(Z_W-30){1'b0}}, ATAN_TAB[idx]});
    endfunction

endpackage

FILE: hdl/prt_cstage.sv
// ----------------------------------------------------------------------------
// prt_cstage
// one registered cordic micro-rotation, carries the point data alongside
// ----------------------------------------------------------------------------
module prt_cstage #(
    parameter int CW    = 32,
    parameter int STAGE = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [prt_pkg::TRIG_W-1:0] in_x,
    input  logic signed [prt_pkg::TRIG_W-1:0] in_y,
    input  logic signed [prt_pkg::Z_W-1:0]    in_z,
    input  logic signed [CW:0]                in_sx,
    input  logic signed [CW:0]                in_sy,
    input  logic signed [CW-1:0]              in_px,
    input  logic signed [CW-1:0]              in_py,
    output logic                              out_valid,
    output logic signed [prt_pkg::TRIG_W-1:0] out_x,
    output logic signed [prt_pkg::TRIG_W-1:0] out_y,
    output logic signed [prt_pkg::Z_W-1:0]    out_z,
    output logic signed [CW:0]                out_sx,
    output logic signed [CW:0]                out_sy,
    output logic signed [CW-1:0]              out_px,
    output logic signed [CW-1:0]              out_py
);
    import prt_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_I = atan_entry(5'(STAGE));

    logic signed [TRIG_W-1:0] dx, dy;
    logic                     pos;
    logic signed [TRIG_W-1:0] x_next, y_next;
    logic signed [Z_W-1:0]    z_next;

    logic                     valid_reg;
    logic signed [TRIG_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [CW:0]       sx_reg, sy_reg;
    logic signed [CW-1:0]     px_reg, py_reg;

    assign dx  = in_y >>> STAGE;
    assign dy  = in_x >>> STAGE;
    assign pos = ~in_z[Z_W-1];

    always_comb begin
        if (pos) begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN_I;
        end else begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN_I;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            sx_reg <= in_sx;
            sy_reg <= in_sy;
            px_reg <= in_px;
            py_reg <= in_py;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_sx    = sx_reg;
    assign out_sy    = sy_reg;
    assign out_px    = px_reg;
    assign out_py    = py_reg;

endmodule

FILE: hdl/prt_mul.sv
// ----------------------------------------------------------------------------
// prt_mul
// four-stage signed multiply by a q1.30 value, rounded half away from zero
// ----------------------------------------------------------------------------
module prt_mul #(
    parameter int AW = 33
) (
    input  logic                                        aclk,
    input  logic                                        en,
    input  logic signed [AW-1:0]                        a,
    input  logic signed [prt_pkg::TRIG_W-1:0]           b,
    output logic signed [AW+prt_pkg::TRIG_W-prt_pkg::FRAC_W:0] p
);
    import prt_pkg::*;

    localparam int BW     = TRIG_W;
    localparam int LO_W   = (AW + 1) / 2;
    localparam int HI_W   = AW - LO_W;
    localparam int FULL_W = AW + BW;
    localparam int MW     = FULL_W - FRAC_W;
    localparam logic [FULL_W-1:0] ROUND_HALF = FULL_W'(1) << (FRAC_W - 1);

    logic [FULL_W-1:0] full_sum;

    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [AW-1:0]     ua_reg;
    logic [BW-1:0]     ub_reg;
    logic [LO_W+BW-1:0] pp_lo_reg;
    logic [HI_W+BW-1:0] pp_hi_reg;
    logic [MW-1:0]     mag_reg;
    logic signed [MW:0] p_reg;

    // operands split in two so no single multiplier grows past 17x33 at the default width
    assign full_sum = {pp_hi_reg, {LO_W{1'b0}}} + FULL_W'(pp_lo_reg) + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (en) begin
            // magnitudes
            neg1_reg  <= a[AW-1] ^ b[BW-1];
            ua_reg    <= a[AW-1] ? AW'(-a) : AW'(a);
            ub_reg    <= b[BW-1] ? BW'(-b) : BW'(b);
            // partial products
            neg2_reg  <= neg1_reg;
            pp_lo_reg <= ua_reg[LO_W-1:0] * ub_reg;
            pp_hi_reg <= ua_reg[AW-1:LO_W] * ub_reg;
            // recombine and round
            neg3_reg  <= neg2_reg;
            mag_reg   <= full_sum[FULL_W-1:FRAC_W];
            // restore sign
            p_reg     <= neg3_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        end
    end

    assign p = p_reg;

endmodule

FILE: hdl/prt_outbuf.sv
// ----------------------------------------------------------------------------
// prt_outbuf
// two-entry output buffer, decouples pipeline advance from m_tready
// ----------------------------------------------------------------------------
module prt_outbuf #(
    parameter int W = 72
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         in_ready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [W-1:0] m_tdata
);
    logic         head_valid_reg, skid_valid_reg;
    logic [W-1:0] head_data_reg, skid_data_reg;
    logic         push, pop;

    assign in_ready = ~skid_valid_reg;
    assign push     = in_valid & in_ready;
    assign pop      = head_valid_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                head_valid_reg <= push;
            end
        end else if (push) begin
            if (!head_valid_reg) begin
                head_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                head_data_reg <= skid_data_reg;
            end else if (push) begin
                head_data_reg <= in_data;
            end
        end else if (push) begin
            if (!head_valid_reg) begin
                head_data_reg <= in_data;
            end else begin
                skid_data_reg <= in_data;
            end
        end
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = head_data_reg;

`ifndef SYNTHESIS
    a_skid_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held without a head entry");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(push) && !$past(pop))
        else $error("skid entry filled without a stalled push");

    a_stall_catches_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid_reg && !m_tready && !skid_valid_reg && in_valid |=> skid_valid_reg)
        else $error("beat dropped while output stalled");
`endif

endmodule

FILE: hdl/point_rotate_translate.sv
// ----------------------------------------------------------------------------
// point_rotate_translate
// pipelined 2d rigid transform, result = R(turn_angle) * (point + pre) + post
// ----------------------------------------------------------------------------
// usage:
//  - one point per s_ beat, one result per m_ beat, in order
//  - coordinates are signed q16.16, turn_angle is a binary angle (2^32 = one
//    counterclockwise turn); sine/cosine come from a gain-compensated cordic
//  - result coordinates saturate to COORD_WIDTH bits; the saturated bit is set
//    when either coordinate was clamped
//  - pipeline: one input stage, one cordic stage per iteration, four multiplier
//    stages, one sum and one clamp stage, then the output register
//  - throughput: one beat per cycle, limited by nothing but m_tready
//  - stalls: the whole pipeline advances together; a two-entry output buffer
//    lets it keep accepting while one finished result waits, s_tready drops
//    only when both entries are full (s_tready comes straight from a flop)
//  - reset: synchronous, active low; empties every stage and the output
//    buffer, no configuration or state survives between beats
// ----------------------------------------------------------------------------
module point_rotate_translate #(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic aclk,
    input  logic aresetn,
    // point_x, point_y, turn_angle[31:0], pre_x, pre_y, post_x, post_y, zero pad
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    input  logic [((6*COORD_WIDTH+32+7)/8)*8-1:0]           s_tdata,
    // result_x, result_y, saturated, zero pad
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0]            m_tdata
);
    import prt_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int N     = CORDIC_STAGES;
    localparam int SW    = CW + 1;                    // point + pre, never clamped
    localparam int OUT_W = ((2*CW+1+7)/8)*8;
    localparam int PW    = SW + TRIG_W - FRAC_W;      // product magnitude width
    localparam int SUM_W = PW + 3;                    // a +/- b + post
    localparam int MUL_STAGES = 4;

    // pipeline advances as one; held only when the output buffer is full
    logic en;

    // ---------------- input field split ----------------
    logic signed [CW-1:0]      f_px, f_py, f_prex, f_prey, f_postx, f_posty;
    logic [ANGLE_W-1:0]        f_ang;

    assign f_px    = s_tdata[CW-1:0];
    assign f_py    = s_tdata[2*CW-1:CW];
    assign f_ang   = s_tdata[2*CW+ANGLE_W-1:2*CW];
    assign f_prex  = s_tdata[3*CW+ANGLE_W-1:2*CW+ANGLE_W];
    assign f_prey  = s_tdata[4*CW+ANGLE_W-1:3*CW+ANGLE_W];
    assign f_postx = s_tdata[5*CW+ANGLE_W-1:4*CW+ANGLE_W];
    assign f_posty = s_tdata[6*CW+ANGLE_W-1:5*CW+ANGLE_W];

    // ---------------- input stage: pre-offset and angle fold ----------------
    logic signed [SW-1:0]     s0_sx_next, s0_sy_next;
    logic signed [Z_W-1:0]    ang_ext, s0_z_next;
    logic signed [TRIG_W-1:0] s0_x_next;
    logic                     fold;

    logic                     s0_valid_reg;
    logic signed [SW-1:0]     s0_sx_reg, s0_sy_reg;
    logic signed [Z_W-1:0]    s0_z_reg;
    logic signed [TRIG_W-1:0] s0_x_reg;
    logic signed [CW-1:0]     s0_px_reg, s0_py_reg;

    assign s0_sx_next = SW'(f_px) + SW'(f_prex);
    assign s0_sy_next = SW'(f_py) + SW'(f_prey);
    assign ang_ext    = $signed({{(Z_W-ANGLE_W){f_ang[ANGLE_W-1]}}, f_ang});

    // beyond an eighth of a turn either way: turn by half a turn and start
    // from the negated vector
    always_comb begin
        if (ang_ext > FOLD_LIMIT) begin
            s0_z_next = ang_ext - HALF_TURN;
            fold      = 1'b1;
        end else if (ang_ext < -FOLD_LIMIT) begin
            s0_z_next = ang_ext + HALF_TURN;
            fold      = 1'b1;
        end else begin
            s0_z_next = ang_ext;
            fold      = 1'b0;
        end
    end

    assign s0_x_next = fold ? -GAIN_INV : GAIN_INV;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_sx_reg <= s0_sx_next;
            s0_sy_reg <= s0_sy_next;
            s0_z_reg  <= s0_z_next;
            s0_x_reg  <= s0_x_next;
            s0_px_reg <= f_postx;
            s0_py_reg <= f_posty;
        end
    end

    // ---------------- cordic: one registered micro-rotation per stage ----------------
    logic                     cv  [0:N];
    logic signed [TRIG_W-1:0] cx  [0:N];
    logic signed [TRIG_W-1:0] cy  [0:N];
    logic signed [Z_W-1:0]    cz  [0:N];
    logic signed [SW-1:0]     csx [0:N];
    logic signed [SW-1:0]     csy [0:N];
    logic signed [CW-1:0]     cpx [0:N];
    logic signed [CW-1:0]     cpy [0:N];

    assign cv[0]  = s0_valid_reg;
    assign cx[0]  = s0_x_reg;
    assign cy[0]  = '0;
    assign cz[0]  = s0_z_reg;
    assign csx[0] = s0_sx_reg;
    assign csy[0] = s0_sy_reg;
    assign cpx[0] = s0_px_reg;
    assign cpy[0] = s0_py_reg;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        prt_cstage #(
            .CW    (CW),
            .STAGE (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[i]),
            .in_x      (cx[i]),
            .in_y      (cy[i]),
            .in_z      (cz[i]),
            .in_sx     (csx[i]),
            .in_sy     (csy[i]),
            .in_px     (cpx[i]),
            .in_py     (cpy[i]),
            .out_valid (cv[i+1]),
            .out_x     (cx[i+1]),
            .out_y     (cy[i+1]),
            .out_z     (cz[i+1]),
            .out_sx    (csx[i+1]),
            .out_sy    (csy[i+1]),
            .out_px    (cpx[i+1]),
            .out_py    (cpy[i+1])
        );
    end

    // residual angle is only steering, the last one is dropped
    logic signed [Z_W-1:0] z_residual;
    assign z_residual = cz[N];

    // ---------------- products: cos = cx[N], sin = cy[N] ----------------
    logic signed [PW:0] p_xc, p_ys, p_xs, p_yc;

    prt_mul #(.AW(SW)) u_mul_xc (.aclk(aclk), .en(en), .a(csx[N]), .b(cx[N]), .p(p_xc));
    prt_mul #(.AW(SW)) u_mul_ys (.aclk(aclk), .en(en), .a(csy[N]), .b(cy[N]), .p(p_ys));
    prt_mul #(.AW(SW)) u_mul_xs (.aclk(aclk), .en(en), .a(csx[N]), .b(cy[N]), .p(p_xs));
    prt_mul #(.AW(SW)) u_mul_yc (.aclk(aclk), .en(en), .a(csy[N]), .b(cx[N]), .p(p_yc));

    // valid and post offsets ride along with the multiplier stages
    logic                 mv_reg  [0:MUL_STAGES-1];
    logic signed [CW-1:0] mpx_reg [0:MUL_STAGES-1];
    logic signed [CW-1:0] mpy_reg [0:MUL_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MUL_STAGES; k++) begin
                mv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            mv_reg[0] <= cv[N];
            for (int k = 1; k < MUL_STAGES; k++) begin
                mv_reg[k] <= mv_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mpx_reg[0] <= cpx[N];
            mpy_reg[0] <= cpy[N];
            for (int k = 1; k < MUL_STAGES; k++) begin
                mpx_reg[k] <= mpx_reg[k-1];
                mpy_reg[k] <= mpy_reg[k-1];
            end
        end
    end

    // ---------------- rotated sum plus post offset ----------------
    logic signed [SUM_W-1:0] sum_x_next, sum_y_next;
    logic                    sum_valid_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;

    assign sum_x_next = SUM_W'(p_xc) - SUM_W'(p_ys) + SUM_W'(mpx_reg[MUL_STAGES-1]);
    assign sum_y_next = SUM_W'(p_xs) + SUM_W'(p_yc) + SUM_W'(mpy_reg[MUL_STAGES-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (en) begin
            sum_valid_reg <= mv_reg[MUL_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    // ---------------- saturation ----------------
    // a value fits when every bit from the coordinate sign bit up agrees
    logic                 fit_x, fit_y;
    logic signed [CW-1:0] res_x_next, res_y_next;
    logic                 res_valid_reg;
    logic signed [CW-1:0] res_x_reg, res_y_reg;
    logic                 res_sat_reg;

    assign fit_x = (&sum_x_reg[SUM_W-1:CW-1]) | ~(|sum_x_reg[SUM_W-1:CW-1]);
    assign fit_y = (&sum_y_reg[SUM_W-1:CW-1]) | ~(|sum_y_reg[SUM_W-1:CW-1]);

    assign res_x_next = fit_x ? sum_x_reg[CW-1:0]
                              : {sum_x_reg[SUM_W-1], {(CW-1){~sum_x_reg[SUM_W-1]}}};
    assign res_y_next = fit_y ? sum_y_reg[CW-1:0]
                              : {sum_y_reg[SUM_W-1], {(CW-1){~sum_y_reg[SUM_W-1]}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (en) begin
            res_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_x_reg   <= res_x_next;
            res_y_reg   <= res_y_next;
            res_sat_reg <= ~(fit_x & fit_y);
        end
    end

    // ---------------- output buffer ----------------
    logic [OUT_W-1:0] out_beat;

    assign out_beat = {{(OUT_W-2*CW-1){1'b0}}, res_sat_reg, res_y_reg, res_x_reg};

    prt_outbuf #(
        .W (OUT_W)
    ) u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid_reg & (z_residual[0] | ~z_residual[0])),
        .in_data  (out_beat),
        .in_ready (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = en;

`ifndef SYNTHESIS
    a_sat_means_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*CW] |->
            m_tdata[CW-1:0] == {1'b0, {(CW-1){1'b1}}} ||
            m_tdata[CW-1:0] == {1'b1, {(CW-1){1'b0}}} ||
            m_tdata[2*CW-1:CW] == {1'b0, {(CW-1){1'b1}}} ||
            m_tdata[2*CW-1:CW] == {1'b1, {(CW-1){1'b0}}})
        else $error("saturated flag without a clamped coordinate");
`endif

endmodule
